### design/phwf_pkg.sv
// phwf_pkg: shared codes and constants for the pixel histogram window finder
// no dependencies; used by the top level by scoped names

package phwf_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_PIXEL   = 2'd0;
    localparam mode_t MODE_ANALYSE = 2'd1;
    localparam mode_t MODE_CLEAR   = 2'd2;

    localparam int PIX_BITS     = 16;
    localparam int POS_BITS     = 24;
    localparam int OUT_CNT_BITS = 24;

    // x / 5 == (x * 52429) >> 18, exact for every 16-bit x
    localparam logic [16:0] DIV5_MUL   = 17'd52429;
    localparam int          DIV5_SHIFT = 18;

endpackage

### design/phwf_ram.sv
// phwf_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module phwf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### design/pixel_histogram_window_finder.sv
// pixel_histogram_window_finder: histogram in one ram, peak search and window walks
// pixel words: one per cycle while s_ready is high, read-modify-write through s1 with forwarding
// analyse word: floor, peak scan from floor to max_bin, walks down and up from the peak, result
// clear word: zeroes every bin, one per cycle unless a pixel write waits; s_ready low
// reset: the same clearing pass runs before the first word is taken
// depends on phwf_pkg and phwf_ram

module pixel_histogram_window_finder #(
    parameter int BIN_BITS   = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  phwf_pkg::mode_t       s_mode,
    input  logic [15:0]           s_pixel_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ok,
    output logic [15:0]           m_peak_bin,
    output logic [15:0]           m_window_low,
    output logic [15:0]           m_window_high,
    output logic [23:0]           m_window_peak_count,
    output logic [15:0]           m_max_level,
    output logic [23:0]           m_max_position
);

    localparam int NUM_BINS = 2 ** BIN_BITS;

    typedef logic [BIN_BITS-1:0]   bin_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [phwf_pkg::PIX_BITS-1:0] pix_t;
    typedef logic [phwf_pkg::POS_BITS-1:0] pos_t;

    localparam count_t COUNT_MAX = '1;
    localparam bin_t   BIN_TOP   = bin_t'(NUM_BINS - 2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_FLOOR = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DOWN  = 3'd4;
    localparam logic [2:0] ST_UP    = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       cfg_zero_reg, cfg_zero_next;
    pix_t       largest_value_reg, largest_value_next;
    pos_t       largest_pos_reg, largest_pos_next;
    pos_t       sample_count_reg, sample_count_next;
    logic       s1_valid_reg, s1_valid_next;
    bin_t       s1_bin_reg, s1_bin_next;
    logic       fwd_valid_reg;
    bin_t       fwd_addr_reg;
    count_t     fwd_data_reg;
    bin_t       ptr_reg, ptr_next;
    logic       rd_pend_reg, rd_pend_next;
    bin_t       rd_tag_reg, rd_tag_next;
    bin_t       floor_reg, floor_next;
    bin_t       max_bin_reg, max_bin_next;
    count_t     best_reg, best_next;
    bin_t       peak_reg, peak_next;
    bin_t       lo_reg, lo_next;
    bin_t       hi_reg, hi_next;
    count_t     wmax_reg, wmax_next;
    logic       res_ok_reg, res_ok_next;
    logic       m_valid_reg, m_valid_next;
    logic       m_ok_reg, m_ok_next;
    logic [15:0] m_peak_reg, m_peak_next;
    logic [15:0] m_low_reg, m_low_next;
    logic [15:0] m_high_reg, m_high_next;
    logic [23:0] m_wcount_reg, m_wcount_next;
    pix_t       m_level_reg, m_level_next;
    pos_t       m_pos_reg, m_pos_next;

    logic        accept;
    bin_t        px_bin;
    bin_t        max_bin_now;
    logic [32:0] div5_prod;
    bin_t        floor_calc;
    bin_t        floor_val;
    count_t      cnt_cur;
    count_t      cnt_inc;
    count_t      floor_cnt;
    logic        low_cnt;
    logic        ram_wr_en;
    bin_t        ram_wr_addr;
    count_t      ram_wr_data;
    bin_t        ram_rd_addr;
    count_t      ram_rd_data;

    phwf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_hist_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign px_bin      = s_pixel_value[15 -: BIN_BITS];
    assign max_bin_now = largest_value_reg[15 -: BIN_BITS];
    assign div5_prod   = {17'd0, 16'(max_bin_now)} * {16'd0, phwf_pkg::DIV5_MUL};
    assign floor_calc  = bin_t'(div5_prod >> phwf_pkg::DIV5_SHIFT);
    assign floor_val   = cfg_zero_reg ? '0 : floor_calc;

    // bin written on the previous edge is not yet visible in the read data
    assign cnt_cur = (fwd_valid_reg && (fwd_addr_reg == s1_bin_reg)) ? fwd_data_reg
                                                                      : ram_rd_data;
    assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + count_t'(1);

    assign floor_cnt = count_t'(floor_reg);
    assign low_cnt   = (ram_rd_data <= floor_cnt);

    always_comb begin
        if (s1_valid_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = s1_bin_reg;
            ram_wr_data = cnt_inc;
        end else if (state_reg == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = 1'b0;
            ram_wr_addr = ptr_reg;
            ram_wr_data = '0;
        end
    end

    assign ram_rd_addr = (state_reg == ST_IDLE) ? px_bin : ptr_reg;

    always_comb begin
        state_next         = state_reg;
        cfg_zero_next      = cfg_zero_reg;
        largest_value_next = largest_value_reg;
        largest_pos_next   = largest_pos_reg;
        sample_count_next  = sample_count_reg;
        s1_valid_next      = 1'b0;
        s1_bin_next        = s1_bin_reg;
        ptr_next           = ptr_reg;
        rd_pend_next       = 1'b0;
        rd_tag_next        = ptr_reg;
        floor_next         = floor_reg;
        max_bin_next       = max_bin_reg;
        best_next          = best_reg;
        peak_next          = peak_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        wmax_next          = wmax_reg;
        res_ok_next        = res_ok_reg;
        m_valid_next       = m_valid_reg;
        m_ok_next          = m_ok_reg;
        m_peak_next        = m_peak_reg;
        m_low_next         = m_low_reg;
        m_high_next        = m_high_reg;
        m_wcount_next      = m_wcount_reg;
        m_level_next       = m_level_reg;
        m_pos_next         = m_pos_reg;

        if (cfg_wr_en) begin
            cfg_zero_next = cfg_wr_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        phwf_pkg::MODE_PIXEL: begin
                            s1_valid_next = 1'b1;
                            s1_bin_next   = px_bin;
                            if (s_pixel_value > largest_value_reg) begin
                                largest_value_next = s_pixel_value;
                                largest_pos_next   = sample_count_reg;
                            end
                            if (sample_count_reg != '1) begin
                                sample_count_next = sample_count_reg + pos_t'(1);
                            end
                        end
                        phwf_pkg::MODE_ANALYSE: begin
                            state_next = ST_FLOOR;
                        end
                        phwf_pkg::MODE_CLEAR: begin
                            state_next         = ST_CLEAR;
                            ptr_next           = '0;
                            largest_value_next = '0;
                            largest_pos_next   = '0;
                            sample_count_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                // sweep waits while a pending pixel owns the write port
                if (!s1_valid_reg) begin
                    ptr_next = ptr_reg + bin_t'(1);
                    if (ptr_reg == '1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLOOR: begin
                max_bin_next = max_bin_now;
                floor_next   = floor_val;
                ptr_next     = floor_val;
                best_next    = '0;
                peak_next    = '0;
                wmax_next    = '0;
                res_ok_next  = 1'b0;
                if (largest_value_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_pend_reg && (ram_rd_data > best_reg)) begin
                    best_next = ram_rd_data;
                    peak_next = rd_tag_reg;
                end
                if (ptr_reg < max_bin_reg) begin
                    rd_pend_next = 1'b1;
                    ptr_next     = ptr_reg + bin_t'(1);
                end else if (!rd_pend_reg) begin
                    if (peak_reg <= bin_t'(1)) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DOWN;
                        ptr_next   = peak_reg - bin_t'(1);
                    end
                end
            end
            ST_DOWN: begin
                if (rd_pend_reg && (low_cnt || (rd_tag_reg == floor_reg) ||
                                    (rd_tag_reg == '0))) begin
                    lo_next    = rd_tag_reg;
                    ptr_next   = peak_reg + bin_t'(1);
                    state_next = ST_UP;
                end else begin
                    if (rd_pend_reg && (ram_rd_data > wmax_reg)) begin
                        wmax_next = ram_rd_data;
                    end
                    rd_pend_next = 1'b1;
                    ptr_next     = ptr_reg - bin_t'(1);
                end
            end
            ST_UP: begin
                if (rd_pend_reg && (low_cnt || (rd_tag_reg >= BIN_TOP))) begin
                    hi_next     = rd_tag_reg;
                    res_ok_next = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    if (rd_pend_reg && (ram_rd_data > wmax_reg)) begin
                        wmax_next = ram_rd_data;
                    end
                    rd_pend_next = 1'b1;
                    ptr_next     = ptr_reg + bin_t'(1);
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_ok_next     = res_ok_reg;
                    m_peak_next   = res_ok_reg ? 16'(peak_reg) : '0;
                    m_low_next    = res_ok_reg ? 16'(lo_reg) : '0;
                    m_high_next   = res_ok_reg ? 16'(hi_reg) : '0;
                    m_wcount_next = res_ok_reg ? 24'(wmax_reg) : '0;
                    m_level_next  = largest_value_reg;
                    m_pos_next    = largest_pos_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            cfg_zero_reg      <= 1'b0;
            largest_value_reg <= '0;
            largest_pos_reg   <= '0;
            sample_count_reg  <= '0;
            s1_valid_reg      <= 1'b0;
            fwd_valid_reg     <= 1'b0;
            ptr_reg           <= '0;
            rd_pend_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            cfg_zero_reg      <= cfg_zero_next;
            largest_value_reg <= largest_value_next;
            largest_pos_reg   <= largest_pos_next;
            sample_count_reg  <= sample_count_next;
            s1_valid_reg      <= s1_valid_next;
            fwd_valid_reg     <= ram_wr_en;
            ptr_reg           <= ptr_next;
            rd_pend_reg       <= rd_pend_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_bin_reg   <= s1_bin_next;
        fwd_addr_reg <= ram_wr_addr;
        fwd_data_reg <= ram_wr_data;
        rd_tag_reg   <= rd_tag_next;
        floor_reg    <= floor_next;
        max_bin_reg  <= max_bin_next;
        best_reg     <= best_next;
        peak_reg     <= peak_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        wmax_reg     <= wmax_next;
        res_ok_reg   <= res_ok_next;
        m_ok_reg     <= m_ok_next;
        m_peak_reg   <= m_peak_next;
        m_low_reg    <= m_low_next;
        m_high_reg   <= m_high_next;
        m_wcount_reg <= m_wcount_next;
        m_level_reg  <= m_level_next;
        m_pos_reg    <= m_pos_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_ok                = m_ok_reg;
    assign m_peak_bin          = m_peak_reg;
    assign m_window_low        = m_low_reg;
    assign m_window_high       = m_high_reg;
    assign m_window_peak_count = m_wcount_reg;
    assign m_max_level         = m_level_reg;
    assign m_max_position      = m_pos_reg;

    ap_pixel_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_mode == phwf_pkg::MODE_PIXEL))
        |=> (ram_wr_en && (ram_wr_addr == $past(px_bin))))
        else $error("pixel word did not write its bin");

    ap_no_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (ram_wr_data != '0))
        else $error("bin count wrapped to zero");

    ap_null_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ok_reg) |-> ((m_peak_reg == '0) && (m_low_reg == '0) &&
                                        (m_high_reg == '0) && (m_wcount_reg == '0)))
        else $error("result without a peak carries window fields");

    ap_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ok_reg) |-> ((m_low_reg < m_peak_reg) && (m_high_reg > m_peak_reg)))
        else $error("window edges do not enclose the peak");

    ap_max_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && (s_mode == phwf_pkg::MODE_CLEAR))
        |=> (largest_value_reg >= $past(largest_value_reg)))
        else $error("largest value dropped without a clear");

endmodule
